// File: sv/fan_curve_interpolator_defines.svh
// assertion macros for the fan curve interpolator
`ifndef FAN_CURVE_INTERPOLATOR_DEFINES_SVH
`define FAN_CURVE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, held off while in reset
`define FCI_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication, held off while in reset
`define FCI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FCI_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define FCI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: sv/fci_pkg.sv
// shared types, constants and helpers for the fan curve interpolator
package fci_pkg;

    localparam int NUM_POINTS    = 6;
    localparam int PT_IDX_W      = 3;
    localparam int TEMP_W        = 8;
    localparam int FAN_W         = 8;
    localparam int FAN_OUT_W     = 7;
    localparam int STATUS_W      = 3;
    localparam int PIU_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam int DEF_MAX_TEMP        = 120;
    localparam int DEF_MAX_FAN_PERCENT = 100;
    localparam int QUEUE_DEPTH         = 4;

    // divider sizing: num <= 255*255, dividend = 2*num + den, quotient < 256
    localparam int PROD_W     = 2 * FAN_W;
    localparam int DIVIDEND_W = PROD_W + 1;
    localparam int QUOT_W     = FAN_W;
    localparam int STEP_CNT_W = 3;

    localparam logic [PIU_W-1:0]      PIU_RESET    = 3'd1;
    localparam logic [CFG_DATA_W-1:0] POINT0_RESET = 16'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_LAST    = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_NOT_RISING  = 3'd2,
        ST_FAN_FALLING = 3'd3,
        ST_LIMIT       = 3'd4
    } status_t;

    // one classified word between front and back
    typedef struct packed {
        logic              direct;   // result known without division
        logic [FAN_W-1:0]  value;
        status_t           status;
        logic [TEMP_W-1:0] t;
        logic [TEMP_W-1:0] tlo;
        logic [TEMP_W-1:0] thi;
        logic [FAN_W-1:0]  flo;
        logic [FAN_W-1:0]  fhi;
    } item_t;

    function automatic logic [FAN_OUT_W-1:0] sat_fan(input logic [FAN_W-1:0] v);
        logic [FAN_OUT_W-1:0] r;
        if (v > FAN_W'((1 << FAN_OUT_W) - 1)) begin
            r = '1;
        end else begin
            r = v[FAN_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/fci_front.sv
// front end: takes samples, checks the curve and picks the segment
module fci_front #(
    parameter int MAX_TEMP        = fci_pkg::DEF_MAX_TEMP,
    parameter int MAX_FAN_PERCENT = fci_pkg::DEF_MAX_FAN_PERCENT
) (
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    input  logic [fci_pkg::IN_TDATA_W-1:0]                       s_tdata,
    input  logic [fci_pkg::PIU_W-1:0]                            points_in_use,
    input  logic [fci_pkg::NUM_POINTS-1:0][fci_pkg::CFG_DATA_W-1:0] curve_point,
    input  logic                                                 q_full,
    output logic                                                 q_push,
    output fci_pkg::item_t                                       q_item
);

    localparam logic [fci_pkg::TEMP_W-1:0] MAX_TEMP_V = fci_pkg::TEMP_W'(MAX_TEMP);
    localparam logic [fci_pkg::FAN_W-1:0]  MAX_FAN_V  = fci_pkg::FAN_W'(MAX_FAN_PERCENT);

    logic [fci_pkg::TEMP_W-1:0]   pt_temp [fci_pkg::NUM_POINTS];
    logic [fci_pkg::FAN_W-1:0]    pt_fan  [fci_pkg::NUM_POINTS];
    logic [fci_pkg::PIU_W-1:0]    n_pts;
    logic [fci_pkg::PT_IDX_W-1:0] last_idx;
    logic [fci_pkg::PT_IDX_W-1:0] seg_idx;
    logic [fci_pkg::PT_IDX_W-1:0] lo_idx;
    logic                         seg_found;
    logic                         limit_err;
    fci_pkg::status_t             pair_status;
    fci_pkg::status_t             status;
    logic [fci_pkg::TEMP_W-1:0]   t;

    always_comb begin
        for (int k = 0; k < fci_pkg::NUM_POINTS; k++) begin
            pt_temp[k] = curve_point[k][fci_pkg::CFG_DATA_W-1:fci_pkg::FAN_W];
            pt_fan[k]  = curve_point[k][fci_pkg::FAN_W-1:0];
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign t        = s_tdata[fci_pkg::TEMP_W-1:0];

    always_comb begin
        n_pts = (points_in_use > fci_pkg::PIU_W'(fci_pkg::NUM_POINTS)) ?
                fci_pkg::PIU_W'(fci_pkg::NUM_POINTS) : points_in_use;
        last_idx = (n_pts == '0) ? '0 : fci_pkg::PT_IDX_W'(n_pts - 1'b1);

        limit_err = 1'b0;
        for (int k = 0; k < fci_pkg::NUM_POINTS; k++) begin
            if (fci_pkg::PIU_W'(k) < n_pts &&
                (pt_temp[k] > MAX_TEMP_V || pt_fan[k] > MAX_FAN_V)) begin
                limit_err = 1'b1;
            end
        end

        // walk downward so the lowest failing pair wins
        pair_status = fci_pkg::ST_OK;
        for (int k = fci_pkg::NUM_POINTS - 1; k >= 1; k--) begin
            if (fci_pkg::PIU_W'(k) < n_pts) begin
                if (pt_temp[k] <= pt_temp[k-1]) begin
                    pair_status = fci_pkg::ST_NOT_RISING;
                end else if (pt_fan[k] < pt_fan[k-1]) begin
                    pair_status = fci_pkg::ST_FAN_FALLING;
                end
            end
        end

        if (limit_err) begin
            status = fci_pkg::ST_LIMIT;
        end else if (n_pts == '0) begin
            status = fci_pkg::ST_EMPTY;
        end else begin
            status = pair_status;
        end

        seg_found = 1'b0;
        seg_idx   = fci_pkg::PT_IDX_W'(1);
        for (int k = fci_pkg::NUM_POINTS - 1; k >= 1; k--) begin
            if (fci_pkg::PIU_W'(k) < n_pts && t >= pt_temp[k-1] && t <= pt_temp[k] &&
                pt_temp[k] > pt_temp[k-1]) begin
                seg_found = 1'b1;
                seg_idx   = fci_pkg::PT_IDX_W'(k);
            end
        end
        lo_idx = seg_idx - 1'b1;

        q_item        = '0;
        q_item.status = status;
        q_item.direct = 1'b1;
        q_item.t      = t;
        q_item.tlo    = pt_temp[lo_idx];
        q_item.thi    = pt_temp[seg_idx];
        q_item.flo    = pt_fan[lo_idx];
        q_item.fhi    = pt_fan[seg_idx];
        if (status != fci_pkg::ST_OK) begin
            q_item.value = MAX_FAN_V;
        end else if (t <= pt_temp[0]) begin
            q_item.value = pt_fan[0];
        end else if (t >= pt_temp[last_idx]) begin
            q_item.value = pt_fan[last_idx];
        end else if (seg_found) begin
            q_item.direct = 1'b0;
            q_item.value  = '0;
        end else begin
            q_item.value = MAX_FAN_V;
        end
    end

endmodule

// File: sv/fci_queue.sv
// short queue of classified words between front and back
module fci_queue #(
    parameter int DEPTH = fci_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fci_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output fci_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fci_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/fci_back.sv
// back end: restoring divider for interpolation and the output register
module fci_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  fci_pkg::item_t                     q_item,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fci_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    typedef enum logic [2:0] {
        BK_LOAD = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic [fci_pkg::DIVIDEND_W-1:0]     rem_reg, rem_next;
    logic [fci_pkg::DIVIDEND_W-1:0]     dsh_reg, dsh_next;
    logic [fci_pkg::QUOT_W-1:0]         quot_reg, quot_next;
    logic [fci_pkg::STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               m_valid_reg;
    logic [fci_pkg::FAN_OUT_W-1:0]      m_fan_reg;
    fci_pkg::status_t                   m_status_reg;

    logic                               out_free;
    logic                               out_load;
    logic [fci_pkg::FAN_OUT_W-1:0]      out_fan;
    fci_pkg::status_t                   out_status;
    logic [fci_pkg::TEMP_W-1:0]         span_hi, span_lo, den;
    logic [fci_pkg::PROD_W-1:0]         prod_lo, prod_hi;
    logic [fci_pkg::DIVIDEND_W-1:0]     num, dividend;
    logic                               fits;

    assign out_free = !m_valid_reg || m_tready;

    // num = f_lo*(t_hi - t) + f_hi*(t - t_lo), dividend = 2*num + den
    always_comb begin
        span_hi  = q_item.thi - q_item.t;
        span_lo  = q_item.t - q_item.tlo;
        den      = q_item.thi - q_item.tlo;
        prod_lo  = fci_pkg::PROD_W'(q_item.flo) * fci_pkg::PROD_W'(span_hi);
        prod_hi  = fci_pkg::PROD_W'(q_item.fhi) * fci_pkg::PROD_W'(span_lo);
        num      = fci_pkg::DIVIDEND_W'(prod_lo) + fci_pkg::DIVIDEND_W'(prod_hi);
        dividend = {num[fci_pkg::DIVIDEND_W-2:0], 1'b0} + fci_pkg::DIVIDEND_W'(den);
    end

    assign fits = (rem_reg >= dsh_reg);

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        out_fan    = fci_pkg::sat_fan(q_item.value);
        out_status = q_item.status;
        case (state_reg)
            BK_LOAD: begin
                if (q_valid) begin
                    if (q_item.direct) begin
                        if (out_free) begin
                            q_pop    = 1'b1;
                            out_load = 1'b1;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        rem_next   = dividend;
                        // 2*den aligned to the top quotient bit
                        dsh_next   = fci_pkg::DIVIDEND_W'({den, {fci_pkg::QUOT_W{1'b0}}});
                        quot_next  = '0;
                        cnt_next   = fci_pkg::STEP_CNT_W'(fci_pkg::QUOT_W - 1);
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quot_next = {quot_reg[fci_pkg::QUOT_W-2:0], fits};
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                out_fan    = fci_pkg::sat_fan(quot_reg);
                out_status = fci_pkg::ST_OK;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = BK_LOAD;
                end
            end
            default: begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        if (out_load) begin
            m_fan_reg    <= out_fan;
            m_status_reg <= out_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = fci_pkg::OUT_TDATA_W'({m_status_reg, m_fan_reg});

endmodule

// File: sv/fan_curve_interpolator.sv
// top level of the fan curve interpolator: configuration registers, front, queue, back
//
// Maps each temperature word to a fan duty word along a curve of up to six breakpoints,
// checked on every word. Input words are taken in consecutive cycles until the four-entry
// queue between front and back is full. A word whose result is known without division
// (curve error, sample at or beyond either end) goes straight to the output register once
// that register is free; a word that falls between two breakpoints holds the back end's
// restoring divider through operand load, eight quotient bits and hand-off to the output
// register, and the back end takes no new word from the queue until that hand-off is done.
// Configuration writes are always taken.
`include "fan_curve_interpolator_defines.svh"

module fan_curve_interpolator #(
    parameter int MAX_TEMP        = fci_pkg::DEF_MAX_TEMP,
    parameter int MAX_FAN_PERCENT = fci_pkg::DEF_MAX_FAN_PERCENT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fci_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] sensor_temp
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fci_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [6:0] fan_percent, [9:7] curve_status
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fci_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [fci_pkg::FAN_OUT_W-1:0] FAN_ERR_OUT =
        fci_pkg::sat_fan(fci_pkg::FAN_W'(MAX_FAN_PERCENT));

    logic [fci_pkg::PIU_W-1:0]                             points_in_use_reg;
    logic [fci_pkg::NUM_POINTS-1:0][fci_pkg::CFG_DATA_W-1:0] curve_point_reg;
    logic [fci_pkg::PT_IDX_W-1:0]                          point_sel;

    logic           q_push, q_full, q_pop, q_valid;
    fci_pkg::item_t push_item, pop_item;

    assign cfg_ready = 1'b1;
    assign point_sel = cfg_index - fci_pkg::CFG_POINT_FIRST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_in_use_reg <= fci_pkg::PIU_RESET;
            // point 0 sits in the lowest bits, the others clear
            curve_point_reg   <= (fci_pkg::NUM_POINTS * fci_pkg::CFG_DATA_W)'(
                                     fci_pkg::POINT0_RESET);
        end else if (cfg_valid) begin
            if (cfg_index == fci_pkg::CFG_POINTS_IN_USE) begin
                points_in_use_reg <= cfg_data[fci_pkg::PIU_W-1:0];
            end else if (cfg_index inside {[fci_pkg::CFG_POINT_FIRST:fci_pkg::CFG_POINT_LAST]})
            begin
                curve_point_reg[point_sel] <= cfg_data;
            end
        end
    end

    fci_front #(
        .MAX_TEMP        (MAX_TEMP),
        .MAX_FAN_PERCENT (MAX_FAN_PERCENT)
    ) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .points_in_use (points_in_use_reg),
        .curve_point   (curve_point_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    fci_queue #(
        .DEPTH (fci_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    fci_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // the front never pushes into a full queue
    `FCI_ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, q_push, !q_full)
    // a curve error always carries maximum fan
    `FCI_ASSERT_IMPLIES(a_err_max_fan, aclk, aresetn,
        m_tvalid && m_tdata[9:7] != fci_pkg::ST_OK, m_tdata[6:0] == FAN_ERR_OUT)
    // no result exceeds the fan limit
    `FCI_ASSERT_IMPLIES(a_fan_in_range, aclk, aresetn, m_tvalid, m_tdata[6:0] <= FAN_ERR_OUT)
    // the back end only pops words that are there
    `FCI_ASSERT_IMPLIES(a_pop_has_word, aclk, aresetn, q_pop, q_valid)

endmodule
